// File: hw/rtl/rdsm_pkg.sv
// rdsm_pkg: shared constants and types for the dot-star regex matcher.
// No dependencies; used by every module of the matcher.
`timescale 1ns / 1ps

package rdsm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int ROW_W       = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CFG_LEN_W   = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int BYTES_PER_WORD = CFG_DATA_W / 8;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_BYTES_LOW      = 2'd1,
    REG_BYTES_HIGH     = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  typedef logic [MAX_PATTERN-1:0][7:0] pattern_t;

  // One classified beat: per-position byte hits plus control flags
  typedef struct packed {
    logic [MAX_PATTERN-1:0] hit;
    logic                   start;
    logic                   query;
  } item_t;

endpackage

// File: hw/rtl/regex_dot_star_matcher.sv
// regex_dot_star_matcher: streaming matcher for patterns with '.' and '*'.
// An accepted text beat is registered in the queue, then the row update registers its result.
// Throughput: one beat per cycle while results are taken (result_ready); the match row advances one item per pop.
// Reset (synchronous): queue empty, no result pending, row = empty-text row, registers 0.
// Depends on rdsm_pkg, rdsm_front and rdsm_back.
`timescale 1ns / 1ps

module regex_dot_star_matcher (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]    write_index,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]   write_data,
  input  logic                              text_valid,
  output logic                              text_ready,
  input  logic [7:0]                        text_byte,
  input  logic                              start_new,
  input  logic                              empty_query,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              full_match
);

  logic [rdsm_pkg::CFG_LEN_W-1:0]  pattern_length;
  logic [rdsm_pkg::CFG_DATA_W-1:0] pattern_bytes_low;
  logic [rdsm_pkg::CFG_DATA_W-1:0] pattern_bytes_high;
  rdsm_pkg::pattern_t              pattern;
  logic [rdsm_pkg::LEN_W-1:0]      used_len;
  logic                            q_valid;
  rdsm_pkg::item_t                 q_item;
  logic                            pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= '0;
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
    end else if (write_enable) begin
      unique case (rdsm_pkg::cfg_reg_t'(write_index))
        rdsm_pkg::REG_PATTERN_LENGTH: pattern_length <= write_data[rdsm_pkg::CFG_LEN_W-1:0];
        rdsm_pkg::REG_BYTES_LOW:      pattern_bytes_low <= write_data;
        rdsm_pkg::REG_BYTES_HIGH:     pattern_bytes_high <= write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < rdsm_pkg::MAX_PATTERN; k++) begin
      if (k < rdsm_pkg::BYTES_PER_WORD) begin
        pattern[k] = pattern_bytes_low[(k % rdsm_pkg::BYTES_PER_WORD)*8 +: 8];
      end else begin
        pattern[k] = pattern_bytes_high[(k % rdsm_pkg::BYTES_PER_WORD)*8 +: 8];
      end
    end
    // lengths past the pattern store clamp to the full pattern
    if (pattern_length > rdsm_pkg::CFG_LEN_W'(rdsm_pkg::MAX_PATTERN)) begin
      used_len = rdsm_pkg::LEN_W'(rdsm_pkg::MAX_PATTERN);
    end else begin
      used_len = rdsm_pkg::LEN_W'(pattern_length);
    end
  end

  rdsm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text_byte   (text_byte),
    .start_new   (start_new),
    .empty_query (empty_query),
    .pattern     (pattern),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop)
  );

  rdsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pattern      (pattern),
    .used_len     (used_len),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .full_match   (full_match)
  );

  // a full queue is never seen as empty by the back end
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !text_ready |-> q_valid)
    else $error("queue full but reported empty");

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> result_valid)
    else $error("popped item produced no result");

endmodule

// File: hw/rtl/rdsm_front.sv
// rdsm_front: accepts text beats, compares the byte against every pattern
// position and queues the classified item. Depends on rdsm_pkg.
`timescale 1ns / 1ps

module rdsm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  output logic              text_ready,
  input  logic [7:0]        text_byte,
  input  logic              start_new,
  input  logic              empty_query,
  input  rdsm_pkg::pattern_t pattern,
  output logic              q_valid,
  output rdsm_pkg::item_t   q_item,
  input  logic              pop
);

  rdsm_pkg::item_t                  entries [rdsm_pkg::QDEPTH];
  logic [rdsm_pkg::QPTR_W-1:0]      wr_ptr;
  logic [rdsm_pkg::QPTR_W-1:0]      rd_ptr;
  logic [rdsm_pkg::QCNT_W-1:0]      count;
  rdsm_pkg::item_t                  cls;
  logic                             push;

  always_comb begin
    for (int k = 0; k < rdsm_pkg::MAX_PATTERN; k++) begin
      cls.hit[k] = (pattern[k] == text_byte) || (pattern[k] == rdsm_pkg::DOT_CHAR);
    end
    cls.start = start_new;
    cls.query = empty_query;
  end

  assign text_ready = (count != rdsm_pkg::QCNT_W'(rdsm_pkg::QDEPTH));
  assign push       = text_valid && text_ready;
  assign q_valid    = (count != '0);
  assign q_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/rdsm_back.sv
// rdsm_back: holds the match row, advances it one queued item per cycle while
// no result is stalled, and registers the full-match result. Depends on rdsm_pkg.
`timescale 1ns / 1ps

module rdsm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rdsm_pkg::pattern_t          pattern,
  input  logic [rdsm_pkg::LEN_W-1:0]  used_len,
  input  logic                        q_valid,
  input  rdsm_pkg::item_t             q_item,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        full_match
);

  logic [rdsm_pkg::ROW_W-1:0]       row;
  logic [rdsm_pkg::ROW_W-1:0]       row_next;
  logic [rdsm_pkg::ROW_W-1:0]       empty_row;
  logic [rdsm_pkg::ROW_W-1:0]       base;
  logic [rdsm_pkg::ROW_W-1:0]       adv;
  logic [rdsm_pkg::MAX_PATTERN-1:0] star;

  // Star chains link bit j to bit j-2, so at most MAX_PATTERN/2 deep.
  always_comb begin
    for (int k = 0; k < rdsm_pkg::MAX_PATTERN; k++) begin
      star[k] = (pattern[k] == rdsm_pkg::STAR_CHAR);
    end

    empty_row    = '0;
    empty_row[0] = 1'b1;
    // leading star matches nothing, so bit 1 stays clear
    for (int j = 2; j <= rdsm_pkg::MAX_PATTERN; j++) begin
      empty_row[j] = (rdsm_pkg::LEN_W'(j) <= used_len) && star[j-1] && empty_row[j-2];
    end

    base = q_item.start ? empty_row : row;

    adv    = '0;
    adv[1] = (used_len != '0) && !star[0] && base[0] && q_item.hit[0];
    for (int j = 2; j <= rdsm_pkg::MAX_PATTERN; j++) begin
      if (rdsm_pkg::LEN_W'(j) <= used_len) begin
        if (star[j-1]) begin
          adv[j] = adv[j-2] || (q_item.hit[j-2] && base[j]);
        end else begin
          adv[j] = base[j-1] && q_item.hit[j-1];
        end
      end
    end

    row_next = q_item.query ? base : adv;
  end

  assign pop = q_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      row          <= rdsm_pkg::ROW_W'(1);
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        row          <= row_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      full_match <= row_next[used_len];
    end
  end

endmodule
